// File: src/rshg_pkg.sv
// Shared types, constants and arithmetic helpers for the RGB sharpen block
// with its luma histogram. No dependencies; compiled first.
`default_nettype none

package rshg_pkg;

	localparam int DEF_MAX_WIDTH  = 1024;
	localparam int DEF_MAX_HEIGHT = 1024;

	localparam int CMD_W     = 2;
	localparam int CHAN_W    = 8;
	localparam int SEL_W     = 3;
	localparam int CFG_W     = 11;
	localparam int CFG_IDX_W = 1;
	localparam int COUNT_W   = 21;
	localparam int NUM_BINS  = 5;
	localparam int SUM_W     = 22;

	localparam int REG_MIN     = 3;
	localparam int WIDTH_RESET = 1024;
	localparam int HEIGHT_RESET = 1024;

	localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

	// weighted luma sum, scaled by 10000
	localparam logic [SUM_W-1:0] LUMA_KR = SUM_W'(2126);
	localparam logic [SUM_W-1:0] LUMA_KG = SUM_W'(7152);
	localparam logic [SUM_W-1:0] LUMA_KB = SUM_W'(722);

	// bin k starts where round(sum / 10000) reaches 51 * k
	localparam logic [SUM_W-1:0] LUMA_T1 = SUM_W'(505000);
	localparam logic [SUM_W-1:0] LUMA_T2 = SUM_W'(1015000);
	localparam logic [SUM_W-1:0] LUMA_T3 = SUM_W'(1525000);
	localparam logic [SUM_W-1:0] LUMA_T4 = SUM_W'(2035000);

	typedef enum logic [CMD_W-1:0] {
		OP_PIXEL = 2'd0,
		OP_DRAIN = 2'd1,
		OP_HIST  = 2'd2,
		OP_IDLE  = 2'd3
	} op_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_WIDTH  = 1'b0,
		REG_HEIGHT = 1'b1
	} reg_idx_t;

	typedef enum logic {
		RES_PIXEL = 1'b0,
		RES_COUNT = 1'b1
	} res_kind_t;

	typedef struct packed {
		logic [CHAN_W-1:0] r;
		logic [CHAN_W-1:0] g;
		logic [CHAN_W-1:0] b;
	} rgb_t;

	typedef struct packed {
		op_t              op;
		logic             emit;
		logic             border;
		logic             last;
		logic             clear;
		logic [SEL_W-1:0] sel;
		rgb_t             px;
	} item_t;

	function automatic logic [CHAN_W-1:0] sharpen_chan(
		input logic [CHAN_W-1:0] ctr,
		input logic [CHAN_W-1:0] top,
		input logic [CHAN_W-1:0] bot,
		input logic [CHAN_W-1:0] lft,
		input logic [CHAN_W-1:0] rgt
	);
		logic signed [11:0] v;
		v = $signed({2'b00, ctr, 2'b00}) + $signed({4'b0000, ctr})
			- $signed({4'b0000, top}) - $signed({4'b0000, bot})
			- $signed({4'b0000, lft}) - $signed({4'b0000, rgt});
		if (v < 12'sd0) begin
			return '0;
		end else if (v > 12'sd255) begin
			return '1;
		end
		return v[CHAN_W-1:0];
	endfunction

	function automatic logic [SUM_W-1:0] luma_sum(input rgb_t p);
		return LUMA_KR * SUM_W'(p.r) + LUMA_KG * SUM_W'(p.g) + LUMA_KB * SUM_W'(p.b);
	endfunction

	function automatic logic [SEL_W-1:0] luma_bin(input logic [SUM_W-1:0] s);
		if (s >= LUMA_T4) begin
			return SEL_W'(4);
		end else if (s >= LUMA_T3) begin
			return SEL_W'(3);
		end else if (s >= LUMA_T2) begin
			return SEL_W'(2);
		end else if (s >= LUMA_T1) begin
			return SEL_W'(1);
		end
		return '0;
	endfunction

endpackage

`default_nettype wire

// File: src/rshg_cfg_if.sv
// Configuration write channel: register index and write data.
// Depends on rshg_pkg.
`default_nettype none

interface rshg_cfg_if import rshg_pkg::*; ();
	logic                 valid;
	logic                 ready;
	logic [CFG_IDX_W-1:0] index;
	logic [CFG_W-1:0]     data;

	modport source(output valid, index, data, input ready);
	modport sink(input valid, index, data, output ready);
endinterface

`default_nettype wire

// File: src/rshg_pix_if.sv
// Input channel: command word with pixel channels and histogram bin select.
// Depends on rshg_pkg.
`default_nettype none

interface rshg_pix_if import rshg_pkg::*; ();
	logic              valid;
	logic              ready;
	logic [CMD_W-1:0]  command;
	logic [CHAN_W-1:0] red_in;
	logic [CHAN_W-1:0] green_in;
	logic [CHAN_W-1:0] blue_in;
	logic [SEL_W-1:0]  bin_select;

	modport source(output valid, command, red_in, green_in, blue_in, bin_select,
		input ready);
	modport sink(input valid, command, red_in, green_in, blue_in, bin_select,
		output ready);
endinterface

`default_nettype wire

// File: src/rshg_res_if.sv
// Result channel: output pixel or histogram count.
// Depends on rshg_pkg.
`default_nettype none

interface rshg_res_if import rshg_pkg::*; ();
	logic               valid;
	logic               ready;
	logic               result_kind;
	logic [CHAN_W-1:0]  red_out;
	logic [CHAN_W-1:0]  green_out;
	logic [CHAN_W-1:0]  blue_out;
	logic [COUNT_W-1:0] bin_count;
	logic               frame_last;

	modport source(output valid, result_kind, red_out, green_out, blue_out, bin_count,
		frame_last, input ready);
	modport sink(input valid, result_kind, red_out, green_out, blue_out, bin_count,
		frame_last, output ready);
endinterface

`default_nettype wire

// File: src/rgb_sharpen_with_grey_histogram.sv
// A result reaches the output through the s1, s2, s3 and output registers.
// Throughput: one word per cycle, set by the middle line buffer (two read ports and
// one write port used every cycle); output stalls back-pressure through the pipe.
// Reset: positions, drain count and histogram bins clear and the sizes return to
// their reset values at once; line buffers have no clearing pass and their contents
// are only used after being written in a frame.
// Depends on rshg_pkg and the rshg_*_if interfaces.
`default_nettype none

module rgb_sharpen_with_grey_histogram import rshg_pkg::*; #(
	parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
	parameter int MAX_HEIGHT = DEF_MAX_HEIGHT
) (
	input  logic         clk,
	input  logic         arst_n,
	rshg_cfg_if.sink     cfg,
	rshg_pix_if.sink     pixels,
	rshg_res_if.source   results
);

	localparam int AW = $clog2(MAX_WIDTH);
	localparam int WW = $clog2(MAX_WIDTH + 1);
	localparam int RW = $clog2(MAX_HEIGHT);
	localparam int HW = $clog2(MAX_HEIGHT + 1);
	localparam int WIDTH_RST  = (WIDTH_RESET > MAX_WIDTH) ? MAX_WIDTH : WIDTH_RESET;
	localparam int HEIGHT_RST = (HEIGHT_RESET > MAX_HEIGHT) ? MAX_HEIGHT : HEIGHT_RESET;

	// configuration and frame position
	logic [WW-1:0] width_q;
	logic [HW-1:0] height_q;
	logic [AW-1:0] col_q;
	logic [RW-1:0] row_q;
	logic [WW-1:0] pend_q;

	// line buffers
	rgb_t mid_mem [MAX_WIDTH];
	rgb_t up_mem  [MAX_WIDTH];

	// pipeline
	logic          s1_v, s2_v, s3_v, out_v_q;
	item_t         item_s1, item_s2, item_s3;
	logic [AW-1:0] wr_addr_s1;
	rgb_t          mid_a_s1, mid_b_s1, up_s1;
	rgb_t          left_q;
	logic [SUM_W-1:0] sum_s3;

	logic [COUNT_W-1:0] bins_q [NUM_BINS];

	res_kind_t          out_kind_q;
	rgb_t               out_px_q;
	logic [COUNT_W-1:0] out_count_q;
	logic               out_last_q;

	logic          cfg_we;
	logic          in_acc, is_pix, is_drain, drain_ok, rd_en, mem_we;
	logic          col_last, row_last;
	logic [AW-1:0] drain_col, rd_addr_a, rd_addr_b;
	op_t           op;
	item_t         new_item;
	logic          out_adv, s3_rdy, s2_rdy, s1_rdy, s3_go, has_res;
	rgb_t          sharp, res_px;
	item_t         s1_out;
	logic [SEL_W-1:0]   bin;
	logic [COUNT_W-1:0] hist_val;

	// ---------------- configuration ----------------
	assign cfg.ready = 1'b1;
	assign cfg_we    = cfg.valid;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q  <= WW'(WIDTH_RST);
			height_q <= HW'(HEIGHT_RST);
		end else if (cfg_we) begin
			unique case (reg_idx_t'(cfg.index))
				REG_WIDTH: begin
					if (int'(cfg.data) < REG_MIN) begin
						width_q <= WW'(REG_MIN);
					end else if (int'(cfg.data) > MAX_WIDTH) begin
						width_q <= WW'(MAX_WIDTH);
					end else begin
						width_q <= WW'(cfg.data);
					end
				end
				REG_HEIGHT: begin
					if (int'(cfg.data) < REG_MIN) begin
						height_q <= HW'(REG_MIN);
					end else if (int'(cfg.data) > MAX_HEIGHT) begin
						height_q <= HW'(MAX_HEIGHT);
					end else begin
						height_q <= HW'(cfg.data);
					end
				end
				default: begin
				end
			endcase
		end
	end

	// ---------------- accept and position ----------------
	assign out_adv = !out_v_q || results.ready;
	assign s3_rdy  = !s3_v || out_adv;
	assign s2_rdy  = !s2_v || s3_rdy;
	assign s1_rdy  = !s1_v || s2_rdy;

	assign pixels.ready = s1_rdy;
	assign in_acc   = pixels.valid && s1_rdy;
	assign op       = op_t'(pixels.command);
	assign drain_ok = pend_q != '0;
	assign is_pix   = in_acc && (op == OP_PIXEL);
	assign is_drain = in_acc && (op == OP_DRAIN) && drain_ok;
	assign col_last = WW'(col_q) == (width_q - WW'(1));
	assign row_last = HW'(row_q) == (height_q - HW'(1));
	assign drain_col = AW'(width_q - pend_q);

	always_comb begin
		new_item        = '0;
		new_item.op     = op;
		new_item.sel    = pixels.bin_select;
		new_item.px     = {pixels.red_in, pixels.green_in, pixels.blue_in};
		unique case (op)
			OP_PIXEL: begin
				new_item.emit   = row_q != '0;
				new_item.border = (row_q == RW'(1)) || (col_q == '0) || col_last;
				new_item.clear  = (col_q == '0) && (row_q == '0);
			end
			OP_DRAIN: begin
				new_item.emit   = drain_ok;
				new_item.border = 1'b1;
				new_item.last   = pend_q == WW'(1);
			end
			OP_HIST, OP_IDLE: begin
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q  <= '0;
			row_q  <= '0;
			pend_q <= '0;
		end else if (cfg_we) begin
			// restart the frame, keep the histogram
			col_q  <= '0;
			row_q  <= '0;
			pend_q <= '0;
		end else if (is_pix) begin
			if (col_last) begin
				col_q <= '0;
				if (row_last) begin
					row_q  <= '0;
					pend_q <= width_q;
				end else begin
					row_q  <= row_q + RW'(1);
					pend_q <= '0;
				end
			end else begin
				col_q  <= col_q + AW'(1);
				pend_q <= '0;
			end
		end else if (is_drain) begin
			pend_q <= pend_q - WW'(1);
		end
	end

	// ---------------- line buffers ----------------
	// Reads are issued at accept, the write-back happens when the item leaves s1.
	// The write column differs from every column read in the same cycle.
	assign rd_en     = is_pix || is_drain;
	assign rd_addr_a = (op == OP_DRAIN) ? drain_col : col_q;
	assign rd_addr_b = col_q + AW'(1);
	assign mem_we    = s1_v && s2_rdy && (item_s1.op == OP_PIXEL);

	always_ff @(posedge clk) begin
		if (rd_en) begin
			mid_a_s1 <= mid_mem[rd_addr_a];
			mid_b_s1 <= mid_mem[rd_addr_b];
		end
		if (mem_we) begin
			mid_mem[wr_addr_s1] <= item_s1.px;
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			up_s1 <= up_mem[col_q];
		end
		if (mem_we) begin
			up_mem[wr_addr_s1] <= mid_a_s1;
		end
	end

	// ---------------- stage 1: sharpen ----------------
	// left neighbor is the previous pixel's center, already moved to the upper line
	always_comb begin
		sharp.r = sharpen_chan(mid_a_s1.r, up_s1.r, item_s1.px.r, left_q.r, mid_b_s1.r);
		sharp.g = sharpen_chan(mid_a_s1.g, up_s1.g, item_s1.px.g, left_q.g, mid_b_s1.g);
		sharp.b = sharpen_chan(mid_a_s1.b, up_s1.b, item_s1.px.b, left_q.b, mid_b_s1.b);
		res_px  = item_s1.border ? mid_a_s1 : sharp;
		s1_out    = item_s1;
		s1_out.px = res_px;
	end

	always_ff @(posedge clk) begin
		if (mem_we) begin
			left_q <= mid_a_s1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_v <= 1'b0;
			s2_v <= 1'b0;
			s3_v <= 1'b0;
		end else begin
			if (s1_rdy) begin
				s1_v <= in_acc;
			end
			if (s2_rdy) begin
				s2_v <= s1_v;
			end
			if (s3_rdy) begin
				s3_v <= s2_v;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_acc) begin
			item_s1    <= new_item;
			wr_addr_s1 <= col_q;
		end
		if (s2_rdy && s1_v) begin
			item_s2 <= s1_out;
		end
		if (s3_rdy && s2_v) begin
			item_s3 <= item_s2;
			sum_s3  <= luma_sum(item_s2.px);
		end
	end

	// ---------------- stage 3: histogram and output ----------------
	assign s3_go   = s3_v && out_adv;
	assign bin     = luma_bin(sum_s3);
	assign has_res = (item_s3.op == OP_HIST) || item_s3.emit;
	assign hist_val = (int'(item_s3.sel) < NUM_BINS) ? bins_q[item_s3.sel] : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NUM_BINS; i++) begin
				bins_q[i] <= '0;
			end
		end else if (s3_go) begin
			for (int i = 0; i < NUM_BINS; i++) begin
				if (item_s3.clear) begin
					bins_q[i] <= '0;
				end else if (item_s3.emit && (int'(bin) == i) && (bins_q[i] != COUNT_MAX)) begin
					bins_q[i] <= bins_q[i] + COUNT_W'(1);
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v_q <= 1'b0;
		end else if (out_adv) begin
			out_v_q <= s3_v && has_res;
		end
	end

	always_ff @(posedge clk) begin
		if (s3_go) begin
			if (item_s3.op == OP_HIST) begin
				out_kind_q  <= RES_COUNT;
				out_px_q    <= '0;
				out_count_q <= hist_val;
				out_last_q  <= 1'b0;
			end else begin
				out_kind_q  <= RES_PIXEL;
				out_px_q    <= item_s3.px;
				out_count_q <= '0;
				out_last_q  <= item_s3.last;
			end
		end
	end

	assign results.valid       = out_v_q;
	assign results.result_kind = out_kind_q;
	assign results.red_out     = out_px_q.r;
	assign results.green_out   = out_px_q.g;
	assign results.blue_out    = out_px_q.b;
	assign results.bin_count   = out_count_q;
	assign results.frame_last  = out_last_q;

	// ---------------- assertions ----------------
	a_no_rw_overlap: assert property (@(posedge clk) disable iff (!arst_n)
		mem_we && rd_en |-> (wr_addr_s1 != rd_addr_a) && (wr_addr_s1 != rd_addr_b)
			&& (wr_addr_s1 != col_q))
		else $error("line buffer write collides with a read in flight");

	a_pend_bound: assert property (@(posedge clk) disable iff (!arst_n)
		pend_q <= width_q)
		else $error("drain count exceeds row width");

	a_col_bound: assert property (@(posedge clk) disable iff (!arst_n)
		WW'(col_q) < width_q)
		else $error("column position beyond row width");

	a_frame_wrap: assert property (@(posedge clk) disable iff (!arst_n)
		is_pix && col_last && row_last && !cfg_we |=> (pend_q == $past(width_q))
			&& (col_q == '0) && (row_q == '0))
		else $error("frame end did not arm the drain");

endmodule

`default_nettype wire
